// ===== design/load_store_multiple_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the load/store multiple sequencer
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LOAD_STORE_MULTIPLE_SEQUENCER_MACROS_SVH
`define LOAD_STORE_MULTIPLE_SEQUENCER_MACROS_SVH

// property must hold at every clock edge out of reset
`define LSMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define LSMS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/lsms_pkg.sv =====
// ---------------------------------------------------------------------------
// lsms_pkg
// Shared types and constants of the load/store multiple sequencer.
// ---------------------------------------------------------------------------
package lsms_pkg;

	typedef enum logic [1:0] {
		CMD_STM  = 2'd0,
		CMD_LDM  = 2'd1,
		CMD_PUSH = 2'd2,
		CMD_POP  = 2'd3
	} cmd_t;

	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_LR = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;

	localparam int SLOTS      = 9;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 80;

	// one classified instruction; slot order is bus order
	typedef struct packed {
		logic             push;
		logic             load;
		logic [SLOTS-1:0] mask;
		logic [31:0]      start_addr;
		logic             wb_ok;
		logic [3:0]       wb_reg;
		logic [31:0]      wb_value;
	} entry_t;

	typedef struct packed {
		logic        transfer_valid;
		logic        is_load;
		logic [3:0]  reg_index;
		logic [31:0] word_address;
		logic        last;
		logic        wb_valid;
		logic [3:0]  wb_reg;
		logic [31:0] wb_value;
	} result_t;

endpackage

// ===== design/load_store_multiple_sequencer.sv =====
// Thumb load/store multiple sequencer (STM, LDM, PUSH, POP).
// Input stream: one instruction per request; tuser carries cmd, tdata the
// register list, LR/PC bit, base register number and base value.
// Output stream: one result per transferred register in bus order; tlast marks
// the final result, which also carries the base writeback. An empty list gives
// a single result with no transfer.
// The first result passes through the queue, the sequencer registers and the
// output register. An instruction gives up to nine transfers, one result per
// transfer, and the back end emits one per cycle while the receiver takes results.
// A two-entry queue between decode and sequencing lets new requests be
// taken while a long instruction is still being walked.
// Reset clears the queue, the sequencer and the output valid flag.
// When the receiver holds tready low the output register holds its result;
// the sequencer then stalls and the queue fills, after which s_axis_tready drops.
// ---------------------------------------------------------------------------
// load_store_multiple_sequencer
// Top level: input decode, instruction queue and transfer sequencer.
// ---------------------------------------------------------------------------
module load_store_multiple_sequencer
	import lsms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [1:0]           s_axis_tuser,   // cmd
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // reg_list, extra_bit, base_reg, base_value
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [1:0]           m_axis_tuser,   // transfer_valid, is_load
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // reg_index, word_address, writeback_valid,
	                                              // writeback_reg, writeback_value
	output logic                 m_axis_tlast    // last
);

	entry_t  dec_entry;
	entry_t  q_entry;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	lsms_front u_front (
		.cmd        (cmd_t'(s_axis_tuser)),
		.reg_list   (s_axis_tdata[7:0]),
		.extra_bit  (s_axis_tdata[8]),
		.base_reg   (s_axis_tdata[11:9]),
		.base_value (s_axis_tdata[43:12]),
		.entry      (dec_entry)
	);

	lsms_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_axis_tvalid),
		.wr_ready (s_axis_tready),
		.wr_data  (dec_entry),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_entry)
	);

	lsms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_valid),
		.rd_ready  (q_ready),
		.rd_data   (q_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tuser = {res.is_load, res.transfer_valid};
	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {7'd0, res.wb_value, res.wb_reg, res.wb_valid,
	                       res.word_address, res.reg_index};

endmodule

// ===== design/lsms_front.sv =====
// ---------------------------------------------------------------------------
// lsms_front
// Decodes one request into a slot mask, start address and writeback.
// ---------------------------------------------------------------------------
module lsms_front
	import lsms_pkg::*;
(
	input  cmd_t        cmd,
	input  logic [7:0]  reg_list,
	input  logic        extra_bit,
	input  logic [2:0]  base_reg,
	input  logic [31:0] base_value,
	output entry_t      entry
);

	logic [31:0]      base_al;
	logic [SLOTS-1:0] mask;
	logic [3:0]       count;
	logic [31:0]      delta;
	logic             push;

	always_comb begin
		push    = (cmd == CMD_PUSH);
		base_al = {base_value[31:2], 2'b00};
		// push: LR in slot 0, then r7 down to r0; otherwise r0..r7 then PC
		if (push) begin
			mask[0] = extra_bit;
			for (int j = 1; j < SLOTS; j++) begin
				mask[j] = reg_list[8 - j];
			end
		end else begin
			mask = {(cmd == CMD_POP) && extra_bit, reg_list};
		end
		count = 4'($countones(mask));
		delta = {26'd0, count, 2'b00};

		entry.push       = push;
		entry.load       = (cmd == CMD_LDM) || (cmd == CMD_POP);
		entry.mask       = mask;
		entry.start_addr = push ? base_al - 32'd4 : base_al;
		entry.wb_ok      = !((cmd == CMD_LDM) && reg_list[base_reg]);
		entry.wb_reg     = ((cmd == CMD_PUSH) || (cmd == CMD_POP)) ? REG_SP : {1'b0, base_reg};
		entry.wb_value   = push ? base_al - delta : base_al + delta;
	end

endmodule

// ===== design/lsms_fifo.sv =====
// ---------------------------------------------------------------------------
// lsms_fifo
// Small queue of decoded instructions between front and back.
// ---------------------------------------------------------------------------
module lsms_fifo
	import lsms_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  entry_t wr_data,
	output logic   rd_valid,
	input  logic   rd_ready,
	output entry_t rd_data
);

	entry_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = (count_q != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (!do_wr && do_rd) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== design/lsms_back.sv =====
// ---------------------------------------------------------------------------
// lsms_back
// Walks the slot mask of one instruction, one transfer per cycle unless the output stalls.
// ---------------------------------------------------------------------------
`include "load_store_multiple_sequencer_macros.svh"

module lsms_back
	import lsms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rd_valid,
	output logic    rd_ready,
	input  entry_t  rd_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic             busy_q;
	logic [SLOTS-1:0] mask_q;
	logic [31:0]      addr_q;
	logic             push_q;
	logic             load_q;
	logic             wb_ok_q;
	logic [3:0]       wb_reg_q;
	logic [31:0]      wb_value_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             take;
	logic             emit;
	logic             is_last;
	logic             pop;
	logic [SLOTS-1:0] next_mask;
	logic [3:0]       slot;
	logic [3:0]       reg_idx;
	result_t          res;

	always_comb begin
		slot = '0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (mask_q[j]) slot = 4'(j);
		end
		if (push_q) reg_idx = (slot == 4'd0) ? REG_LR : 4'd8 - slot;
		else        reg_idx = (slot == 4'd8) ? REG_PC : {1'b0, slot[2:0]};

		next_mask = mask_q & (mask_q - 1'b1);
		is_last   = (next_mask == '0);
		take      = !out_valid_q || out_ready;
		emit      = busy_q && take;
		rd_ready  = !busy_q || (emit && is_last);
		pop       = rd_valid && rd_ready;

		// an empty list gives one result with no transfer
		res.transfer_valid = (mask_q != '0);
		res.is_load        = load_q;
		res.reg_index      = (mask_q != '0) ? reg_idx : 4'd0;
		res.word_address   = (mask_q != '0) ? addr_q : 32'd0;
		res.last           = is_last;
		res.wb_valid       = is_last && wb_ok_q;
		res.wb_reg         = is_last ? wb_reg_q : 4'd0;
		res.wb_value       = is_last ? wb_value_q : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) busy_q <= 1'b1;
			else if (emit && is_last) busy_q <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q     <= rd_data.mask;
			addr_q     <= rd_data.start_addr;
			push_q     <= rd_data.push;
			load_q     <= rd_data.load;
			wb_ok_q    <= rd_data.wb_ok;
			wb_reg_q   <= rd_data.wb_reg;
			wb_value_q <= rd_data.wb_value;
		end else if (emit) begin
			mask_q <= next_mask;
			addr_q <= push_q ? addr_q - 32'd4 : addr_q + 32'd4;
		end
		if (emit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LSMS_ASSERT(a_stay_busy, emit && !is_last |=> busy_q, "sequencer dropped an instruction early")
	`LSMS_ASSERT(a_mask_shrink, emit && !is_last |=> $countones(mask_q) + 1 == $countones($past(mask_q)), "slot mask did not lose exactly one bit")
	`LSMS_NEVER(a_empty_last, out_valid_q && !out_q.transfer_valid && !out_q.last, "no-transfer result not marked last")
	`LSMS_NEVER(a_wb_on_last, out_valid_q && !out_q.last && out_q.wb_valid, "writeback on a non-final result")

endmodule
